/* rtl/core/palette_linear_fade_assert.svh */
// Assertion macros for the palette fade RTL.
`ifndef PALETTE_LINEAR_FADE_ASSERT_SVH
`define PALETTE_LINEAR_FADE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PLF_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PLF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/core/plf_pkg.sv */
package plf_pkg;

  localparam int ENTRIES    = 64;
  localparam int AW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = AW + 1;
  localparam int FRAC_BITS  = 8;
  localparam int CH_BITS    = 3;
  localparam int NUM_CH     = 3;
  localparam int MAG_W      = CH_BITS + FRAC_BITS;
  localparam int DC_W       = $clog2(MAG_W + 1);
  localparam int ACC_W      = 16;
  localparam int WORD_W     = NUM_CH * ACC_W;
  localparam int ROUND      = (1 << (FRAC_BITS - 1)) - 1;
  localparam int NF_W       = 15;
  localparam int PS_W       = 7;
  localparam int IDX_W      = 6;
  localparam int COLOR_W    = 12;
  localparam int CHAN_LSB0  = 1;
  localparam int CHAN_STEP  = 4;
  localparam int CMDQ_DEPTH = 4;
  localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);
  localparam int OQ_SW      = OQ_CW + 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic CFG_NUM_FRAMES   = 1'b0;
  localparam logic CFG_PALETTE_SIZE = 1'b1;

  typedef enum logic {
    CMD_LOAD,
    CMD_STEP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [AW-1:0]      idx;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] end_color;
  } cmd_t;

  typedef struct packed {
    logic               active;
    logic [IDX_W-1:0]   out_index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } result_t;

endpackage

/* rtl/core/palette_linear_fade.sv */
// Linear palette fade. Push a load transaction (op 0) to set one entry's start and end
// colors and restart the frame count; push a step transaction (op 1) to advance every
// entry in use by one frame and pop one color per entry, last set on the final one, or a
// single inactive result once the fade is over. A load occupies the engine while the
// one-bit-per-cycle divider forms the per-frame steps. A step walks the palette size,
// capped at 64, one entry a cycle while the result queue has room, through the single
// read port of the accumulator memory; a zero palette size emits no color. A full
// result queue holds the engine until a result is popped. A four-deep command queue
// and a four-deep result queue let either side stall alone. Memories need no clearing
// after reset: reading an entry never loaded returns an unspecified color.
module palette_linear_fade (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           op_i,
  input  logic [plf_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [plf_pkg::COLOR_W-1:0]    start_color_i,
  input  logic [plf_pkg::COLOR_W-1:0]    end_color_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           active_o,
  output logic [plf_pkg::IDX_W-1:0]      out_index_o,
  output logic [plf_pkg::COLOR_W-1:0]    color_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [plf_pkg::NF_W-1:0]       cfg_wdata_i
);

  logic [plf_pkg::NF_W-1:0]    num_frames_q;
  logic [plf_pkg::PS_W-1:0]    palette_size_q;
  logic                        cmd_valid, cmd_pop, res_push;
  plf_pkg::cmd_t               cmd;
  plf_pkg::result_t            res, res_out;
  logic [plf_pkg::OQ_CW-1:0]   out_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q   <= plf_pkg::NF_W'(16);
      palette_size_q <= plf_pkg::PS_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        plf_pkg::CFG_NUM_FRAMES:   num_frames_q   <= cfg_wdata_i;
        plf_pkg::CFG_PALETTE_SIZE: palette_size_q <= cfg_wdata_i[plf_pkg::PS_W-1:0];
        default: ;
      endcase
    end
  end

  plf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .start_color_i (start_color_i),
    .end_color_i   (end_color_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  plf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .num_frames_i   (num_frames_q),
    .palette_size_i (palette_size_q),
    .out_cnt_i      (out_cnt),
    .res_push_o     (res_push),
    .res_o          (res)
  );

  plf_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .pop    (pop),
    .empty  (empty),
    .data_o (res_out),
    .cnt_o  (out_cnt)
  );

  assign active_o    = res_out.active;
  assign out_index_o = res_out.out_index;
  assign color_o     = res_out.color;
  assign last_o      = res_out.last;

endmodule

/* rtl/core/plf_ram.sv */
module plf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/core/plf_front.sv */
module plf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           op_i,
  input  logic [plf_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [plf_pkg::COLOR_W-1:0]    start_color_i,
  input  logic [plf_pkg::COLOR_W-1:0]    end_color_i,
  output logic                           cmd_valid_o,
  output plf_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_pop_i
);

  plf_pkg::cmd_t                  mem_q [plf_pkg::CMDQ_DEPTH];
  logic [plf_pkg::CQ_AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [plf_pkg::CQ_CW-1:0]      cnt_q;
  logic                           accept, keep, enq, deq;
  plf_pkg::cmd_t                  cmd_in;

  assign full   = (cnt_q == plf_pkg::CQ_CW'(plf_pkg::CMDQ_DEPTH));
  assign accept = push && !full;

  // Drop loads whose index is not below ENTRIES (64).
  always_comb begin
    cmd_in             = '0;
    cmd_in.idx         = plf_pkg::AW'(entry_index_i);
    cmd_in.start_color = start_color_i;
    cmd_in.end_color   = end_color_i;
    if (op_i == plf_pkg::OP_STEP) begin
      cmd_in.kind = plf_pkg::CMD_STEP;
      keep        = 1'b1;
    end else begin
      cmd_in.kind = plf_pkg::CMD_LOAD;
      keep        = (32'(entry_index_i) < plf_pkg::ENTRIES);
    end
  end

  assign enq         = accept && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign deq         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + plf_pkg::CQ_AW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + plf_pkg::CQ_AW'(1);
      end
      if (enq && !deq) begin
        cnt_q <= cnt_q + plf_pkg::CQ_CW'(1);
      end else if (deq && !enq) begin
        cnt_q <= cnt_q - plf_pkg::CQ_CW'(1);
      end
    end
  end

endmodule

/* rtl/core/plf_outq.sv */
module plf_outq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  plf_pkg::result_t            data_i,
  input  logic                        pop,
  output logic                        empty,
  output plf_pkg::result_t            data_o,
  output logic [plf_pkg::OQ_CW-1:0]   cnt_o
);

  plf_pkg::result_t             mem_q [plf_pkg::OUTQ_DEPTH];
  logic [plf_pkg::OQ_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [plf_pkg::OQ_CW-1:0]    cnt_q;
  logic                         deq;

  assign empty  = (cnt_q == '0);
  assign deq    = pop && !empty;
  assign data_o = mem_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + plf_pkg::OQ_AW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + plf_pkg::OQ_AW'(1);
      end
      if (push_i && !deq) begin
        cnt_q <= cnt_q + plf_pkg::OQ_CW'(1);
      end else if (deq && !push_i) begin
        cnt_q <= cnt_q - plf_pkg::OQ_CW'(1);
      end
    end
  end

endmodule

/* rtl/core/plf_back.sv */
`include "palette_linear_fade_assert.svh"

module plf_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  plf_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  input  logic [plf_pkg::NF_W-1:0]     num_frames_i,
  input  logic [plf_pkg::PS_W-1:0]     palette_size_i,
  input  logic [plf_pkg::OQ_CW-1:0]    out_cnt_i,
  output logic                         res_push_o,
  output plf_pkg::result_t             res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_STEP = 2'd3;

  logic [1:0]                                    state_q, state_d;
  logic [plf_pkg::NF_W-1:0]                      frames_q, frames_d;
  logic [plf_pkg::AW-1:0]                        ld_idx_q, ld_idx_d, i_q, i_d;
  logic [plf_pkg::CNT_W-1:0]                     n_q, n_d, n_sat;
  logic [plf_pkg::DC_W-1:0]                      dcnt_q, dcnt_d;
  logic [plf_pkg::NUM_CH-1:0][plf_pkg::MAG_W-1:0] dvd_q, dvd_d, quo_q, quo_d;
  logic [plf_pkg::NUM_CH-1:0][plf_pkg::NF_W-1:0]  rem_q, rem_d;
  logic [plf_pkg::NUM_CH-1:0][plf_pkg::NF_W:0]    r_ext;
  logic [plf_pkg::NUM_CH-1:0][plf_pkg::CH_BITS-1:0] st_q, st_d;
  logic [plf_pkg::NUM_CH-1:0]                    neg_q, neg_d, ge;
  logic                                          pend_q, pend_d, pend_last_q, pend_last_d;
  logic [plf_pkg::AW-1:0]                        pend_idx_q, pend_idx_d;

  logic                                          acc_we, step_we, rd_en;
  logic [plf_pkg::AW-1:0]                        acc_waddr, rd_addr;
  logic [plf_pkg::WORD_W-1:0]                    acc_wdata, acc_rdata, step_rdata;
  logic [plf_pkg::WORD_W-1:0]                    init_acc, init_step, sum_word;
  logic [plf_pkg::COLOR_W-1:0]                   sum_color;
  logic [15:0]                                   psz16;
  logic                                          room, n_last;

  plf_ram #(
    .Width (plf_pkg::WORD_W),
    .Depth (plf_pkg::ENTRIES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (acc_rdata)
  );

  plf_ram #(
    .Width (plf_pkg::WORD_W),
    .Depth (plf_pkg::ENTRIES)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (step_we),
    .waddr_i (ld_idx_q),
    .wdata_i (init_step),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (step_rdata)
  );

  assign psz16 = 16'(palette_size_i);
  assign n_sat = (psz16 > 16'(plf_pkg::ENTRIES)) ? plf_pkg::CNT_W'(plf_pkg::ENTRIES)
                                                  : plf_pkg::CNT_W'(psz16);
  assign room   = (plf_pkg::OQ_SW'(out_cnt_i) + plf_pkg::OQ_SW'(pend_q))
                  < plf_pkg::OQ_SW'(plf_pkg::OUTQ_DEPTH);
  assign n_last = ((plf_pkg::CNT_W'(i_q) + plf_pkg::CNT_W'(1)) == n_q);

  // Restoring divide lanes, one quotient bit a cycle; load setup and writeback words.
  always_comb begin
    logic [plf_pkg::ACC_W-1:0]   q16;
    logic [plf_pkg::ACC_W-1:0]   a16;
    sum_color = '0;
    for (int c = 0; c < plf_pkg::NUM_CH; c++) begin
      r_ext[c] = {rem_q[c], dvd_q[c][plf_pkg::MAG_W-1]};
      ge[c]    = (r_ext[c] >= {1'b0, num_frames_i});
      init_acc[c*plf_pkg::ACC_W +: plf_pkg::ACC_W] =
        plf_pkg::ACC_W'({st_q[c], {plf_pkg::FRAC_BITS{1'b0}}})
        + plf_pkg::ACC_W'(plf_pkg::ROUND);
      q16 = plf_pkg::ACC_W'(quo_q[c]);
      if (num_frames_i == '0) begin
        init_step[c*plf_pkg::ACC_W +: plf_pkg::ACC_W] = '0;
      end else if (neg_q[c]) begin
        init_step[c*plf_pkg::ACC_W +: plf_pkg::ACC_W] = '0 - q16;
      end else begin
        init_step[c*plf_pkg::ACC_W +: plf_pkg::ACC_W] = q16;
      end
      a16 = acc_rdata[c*plf_pkg::ACC_W +: plf_pkg::ACC_W]
            + step_rdata[c*plf_pkg::ACC_W +: plf_pkg::ACC_W];
      sum_word[c*plf_pkg::ACC_W +: plf_pkg::ACC_W] = a16;
      sum_color[plf_pkg::CHAN_LSB0 + plf_pkg::CHAN_STEP*c +: plf_pkg::CH_BITS] =
        a16[plf_pkg::FRAC_BITS +: plf_pkg::CH_BITS];
    end
  end

  always_comb begin
    logic [plf_pkg::CH_BITS-1:0] s, e, mag;
    s           = '0;
    e           = '0;
    mag         = '0;
    state_d     = state_q;
    frames_d    = frames_q;
    ld_idx_d    = ld_idx_q;
    i_d         = i_q;
    n_d         = n_q;
    dcnt_d      = dcnt_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    st_d        = st_q;
    neg_d       = neg_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    pend_idx_d  = pend_idx_q;
    cmd_pop_o   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = i_q;
    step_we     = 1'b0;
    acc_we      = pend_q;
    acc_waddr   = pend_idx_q;
    acc_wdata   = sum_word;
    res_push_o  = pend_q;
    res_o.active    = 1'b1;
    res_o.out_index = plf_pkg::IDX_W'(pend_idx_q);
    res_o.color     = sum_color;
    res_o.last      = pend_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !pend_q) begin
          if (cmd_i.kind == plf_pkg::CMD_LOAD) begin
            cmd_pop_o = 1'b1;
            ld_idx_d  = cmd_i.idx;
            dcnt_d    = '0;
            for (int c = 0; c < plf_pkg::NUM_CH; c++) begin
              s = cmd_i.start_color[plf_pkg::CHAN_LSB0 + plf_pkg::CHAN_STEP*c +:
                                    plf_pkg::CH_BITS];
              e = cmd_i.end_color[plf_pkg::CHAN_LSB0 + plf_pkg::CHAN_STEP*c +:
                                  plf_pkg::CH_BITS];
              neg_d[c] = (e < s);
              mag      = (e < s) ? (s - e) : (e - s);
              st_d[c]  = s;
              dvd_d[c] = {mag, {plf_pkg::FRAC_BITS{1'b0}}};
              quo_d[c] = '0;
              rem_d[c] = '0;
            end
            state_d = ST_DIV;
          end else if (frames_q == '0) begin
            if (room) begin
              cmd_pop_o       = 1'b1;
              res_push_o      = 1'b1;
              res_o.active    = 1'b0;
              res_o.out_index = '0;
              res_o.color     = '0;
              res_o.last      = 1'b1;
            end
          end else if (n_sat == '0) begin
            cmd_pop_o = 1'b1;
            frames_d  = frames_q - plf_pkg::NF_W'(1);
          end else begin
            cmd_pop_o = 1'b1;
            n_d       = n_sat;
            i_d       = '0;
            state_d   = ST_STEP;
          end
        end
      end
      ST_DIV: begin
        for (int c = 0; c < plf_pkg::NUM_CH; c++) begin
          rem_d[c] = ge[c] ? plf_pkg::NF_W'(r_ext[c] - {1'b0, num_frames_i})
                           : plf_pkg::NF_W'(r_ext[c]);
          quo_d[c] = {quo_q[c][plf_pkg::MAG_W-2:0], ge[c]};
          dvd_d[c] = {dvd_q[c][plf_pkg::MAG_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + plf_pkg::DC_W'(1);
        if (dcnt_q == plf_pkg::DC_W'(plf_pkg::MAG_W - 1)) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        acc_we    = 1'b1;
        acc_waddr = ld_idx_q;
        acc_wdata = init_acc;
        step_we   = 1'b1;
        frames_d  = num_frames_i;
        state_d   = ST_IDLE;
      end
      ST_STEP: begin
        if (room) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_idx_d  = i_q;
          pend_last_d = n_last;
          if (n_last) begin
            frames_d = frames_q - plf_pkg::NF_W'(1);
            state_d  = ST_IDLE;
          end else begin
            i_d = i_q + plf_pkg::AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ld_idx_q    <= ld_idx_d;
    i_q         <= i_d;
    n_q         <= n_d;
    dcnt_q      <= dcnt_d;
    dvd_q       <= dvd_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    st_q        <= st_d;
    neg_q       <= neg_d;
    pend_last_q <= pend_last_d;
    pend_idx_q  <= pend_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      frames_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      frames_q <= frames_d;
      pend_q   <= pend_d;
    end
  end

  `PLF_ASSERT_IMPL(a_push_room, res_push_o,
                   out_cnt_i < plf_pkg::OQ_CW'(plf_pkg::OUTQ_DEPTH), "result queue overrun")
  `PLF_ASSERT_IMPL(a_pop_idle, cmd_pop_o, (state_q == ST_IDLE) && !pend_q,
                   "command taken while busy")
  `PLF_ASSERT_IMPL(a_acc_port, acc_we && rd_en, acc_waddr != rd_addr,
                   "accumulator read and write collide")
  `PLF_ASSERT(a_frames_load, (state_q == ST_WR) |=> (frames_q == $past(num_frames_i)),
              "frame counter not reloaded")

endmodule
